### sv/ebjg_pkg.sv
// Shared types and constants for the exponential backoff jitter generator.
// Used by the divider, the core sequencer and the top level; no dependencies.
`default_nettype none

package ebjg_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned JIT_W  = 15;
    localparam int unsigned STEP_W = 6;

    localparam logic [DATA_W-1:0] LCG_MUL  = 32'd1103515245;
    localparam logic [DATA_W-1:0] LCG_INC  = 32'd12345;
    localparam logic [DATA_W-1:0] JIT_MASK = 32'h0000_7FFF;

    localparam logic [STEP_W-1:0] STEPS_CAP = 6'd32;
    localparam logic [STEP_W-1:0] STEPS_JIT = 6'd15;

    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_SEED    = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EXHAUST = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    localparam logic [1:0] REG_RETRY_LIMIT = 2'd0;
    localparam logic [1:0] REG_BASE_DELAY  = 2'd1;
    localparam logic [1:0] REG_MAX_DELAY   = 2'd2;
    localparam logic [1:0] REG_JITTER_MAX  = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] retry_limit;
        logic [DATA_W-1:0] base_delay;
        logic [DATA_W-1:0] max_delay;
        logic [DATA_W-1:0] jitter_max;
    } t_cfg;

endpackage

`default_nettype wire

### sv/ebjg_div.sv
// Serial restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on ebjg_pkg for widths.
`default_nettype none

module ebjg_div
    import ebjg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [STEP_W-1:0] i_steps,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [DATA_W-1:0]      o_quot,
    output logic [DATA_W-1:0]      o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DATA_W-1:0] r_dvd;
    logic [DATA_W-1:0] r_dvs;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quot;

    logic [DATA_W:0]   n_trial;
    logic              n_ge;
    logic [DATA_W:0]   n_diff;

    always_comb begin
        n_trial = {r_rem, r_dvd[DATA_W-1]};
        n_ge    = (n_trial >= {1'b0, r_dvs});
        n_diff  = n_trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == STEP_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_dvd  <= {r_dvd[DATA_W-2:0], 1'b0};
                r_rem  <= n_ge ? n_diff[DATA_W-1:0] : n_trial[DATA_W-1:0];
                r_quot <= {r_quot[DATA_W-2:0], n_ge};
                r_cnt  <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### sv/ebjg_core.sv
// Sequencer and datapath for one backoff request, with the result register.
// Depends on ebjg_pkg and drives the shared divider ebjg_div.
`default_nettype none

module ebjg_core
    import ebjg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_kind,
    input  wire logic [DATA_W-1:0] i_seed_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_status,
    output logic [DATA_W-1:0]      o_delay_ms,
    output logic [DATA_W-1:0]      o_attempts_done,
    output logic [DATA_W-1:0]      o_total_waited,
    output logic                   o_exhausted
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_CAP_WAIT = 4'd2;
    localparam logic [3:0] S_SCALE    = 4'd3;
    localparam logic [3:0] S_LCG      = 4'd4;
    localparam logic [3:0] S_MOD      = 4'd5;
    localparam logic [3:0] S_MOD_WAIT = 4'd6;
    localparam logic [3:0] S_ADD      = 4'd7;
    localparam logic [3:0] S_CLAMP    = 4'd8;
    localparam logic [3:0] S_UPDATE   = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]        r_state;
    logic [1:0]        r_kind;
    logic [DATA_W-1:0] r_seed;
    logic [DATA_W-1:0] r_lcg;
    logic [DATA_W-1:0] r_att;
    logic [DATA_W-1:0] r_sum;
    logic              r_exh;
    logic [1:0]        r_status;
    logic [DATA_W-1:0] r_delay;
    logic [JIT_W-1:0]  r_jit;

    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [DATA_W-1:0] r_out_delay;
    logic [DATA_W-1:0] r_out_att;
    logic [DATA_W-1:0] r_out_sum;
    logic              r_out_exh;

    logic              n_div_start;
    logic [STEP_W-1:0] n_div_steps;
    logic [DATA_W-1:0] n_div_dvd;
    logic [DATA_W-1:0] n_div_dvs;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;
    logic [DATA_W-1:0] div_rem;

    logic              n_pow_lt;
    logic [DATA_W:0]   n_jit_sum;
    logic [DATA_W:0]   n_wait_sum;
    logic [JIT_W-1:0]  n_draw;
    logic              n_out_free;

    always_comb begin
        n_pow_lt   = (r_att[DATA_W-1:5] == '0)
                     && ((DATA_W'(1) << r_att[4:0]) < div_quot);
        n_jit_sum  = {1'b0, r_delay} + (DATA_W+1)'(r_jit);
        n_wait_sum = {1'b0, r_sum} + {1'b0, r_delay};
        n_draw     = r_lcg[30:16];
        n_out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_div_start = 1'b0;
        n_div_steps = STEPS_CAP;
        n_div_dvd   = i_cfg.max_delay;
        n_div_dvs   = i_cfg.base_delay;
        if (r_state == S_CHECK) begin
            n_div_start = (r_kind == KIND_REQUEST)
                          && (i_cfg.base_delay != '0)
                          && (i_cfg.max_delay >= i_cfg.base_delay)
                          && !r_exh
                          && !((i_cfg.retry_limit != '0) && (r_att >= i_cfg.retry_limit));
        end else if (r_state == S_MOD) begin
            n_div_start = (i_cfg.jitter_max < JIT_MASK);
            n_div_steps = STEPS_JIT;
            n_div_dvd   = {n_draw, {(DATA_W-JIT_W){1'b0}}};
            n_div_dvs   = i_cfg.jitter_max + DATA_W'(1);
        end
    end

    ebjg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_steps    (n_div_steps),
        .i_dividend (n_div_dvd),
        .i_divisor  (n_div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lcg       <= '0;
            r_att       <= '0;
            r_sum       <= '0;
            r_exh       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && n_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind  <= i_kind;
                        r_seed  <= i_seed_value;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_delay <= '0;
                    case (r_kind)
                        KIND_REQUEST: begin
                            if ((i_cfg.base_delay == '0)
                                || (i_cfg.max_delay < i_cfg.base_delay)) begin
                                r_status <= STAT_INVALID;
                                r_state  <= S_DONE;
                            end else if (r_exh) begin
                                r_status <= STAT_EXHAUST;
                                r_state  <= S_DONE;
                            end else if ((i_cfg.retry_limit != '0)
                                         && (r_att >= i_cfg.retry_limit)) begin
                                r_exh    <= 1'b1;
                                r_status <= STAT_EXHAUST;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= STAT_OK;
                                r_state  <= S_CAP_WAIT;
                            end
                        end
                        KIND_RESTART: begin
                            r_status <= STAT_OK;
                            r_state  <= S_DONE;
                            r_att    <= '0;
                            r_sum    <= '0;
                            r_exh    <= 1'b0;
                        end
                        KIND_SEED: begin
                            r_status <= STAT_OK;
                            r_state  <= S_DONE;
                            r_lcg    <= r_seed;
                        end
                        default: begin
                            r_status <= STAT_OK;
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_CAP_WAIT: begin
                    if (div_done) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_delay <= n_pow_lt ? (i_cfg.base_delay << r_att[4:0])
                                        : (i_cfg.max_delay - div_rem);
                    r_state <= (i_cfg.jitter_max == '0) ? S_UPDATE : S_LCG;
                end
                S_LCG: begin
                    r_lcg   <= r_lcg * LCG_MUL + LCG_INC;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (i_cfg.jitter_max >= JIT_MASK) begin
                        r_jit   <= n_draw;
                        r_state <= S_ADD;
                    end else begin
                        r_state <= S_MOD_WAIT;
                    end
                end
                S_MOD_WAIT: begin
                    if (div_done) begin
                        r_jit   <= div_rem[JIT_W-1:0];
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_delay <= n_jit_sum[DATA_W] ? '1 : n_jit_sum[DATA_W-1:0];
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if ((r_delay > i_cfg.max_delay)
                        && (i_cfg.jitter_max < i_cfg.max_delay)) begin
                        r_delay <= i_cfg.max_delay;
                    end
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (r_att != '1) begin
                        r_att <= r_att + DATA_W'(1);
                    end
                    r_sum   <= n_wait_sum[DATA_W] ? '1 : n_wait_sum[DATA_W-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && n_out_free) begin
            r_out_status <= r_status;
            r_out_delay  <= r_delay;
            r_out_att    <= r_att;
            r_out_sum    <= r_sum;
            r_out_exh    <= r_exh;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_delay_ms      = r_out_delay;
    assign o_attempts_done = r_out_att;
    assign o_total_waited  = r_out_sum;
    assign o_exhausted     = r_out_exh;

endmodule

`default_nettype wire

### sv/exponential_backoff_jitter_generator_unit.sv
// Top level of the exponential backoff jitter generator: configuration registers
// and stream ports. Depends on ebjg_pkg and ebjg_core.
//
//  Channel   Direction  Handshake                     Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready   one request item
//  m_axis    out        m_axis_tvalid/m_axis_tready   one result per request
//  cfg       in         i_cfg_we                      register write
//
// A delay request whose jitter needs a modulo runs the 32-step serial division for
// the cap and then the 15-step division for the jitter.
// Restart, seed load and rejected requests go from the check straight to the result.
// Reset is synchronous and active low; it restores registers and counters.
// The result register lets a new request start while the last result waits.
`default_nettype none

module exponential_backoff_jitter_generator_unit
    import ebjg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [DATA_W-1:0]  i_cfg_wdata,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [31:0]        s_axis_tdata,  // [31:0] seed_value
    input  wire logic [1:0]         s_axis_tuser,  // [1:0] kind
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [31:0] delay_ms, [63:32] attempts_done, [95:64] total_waited, [96] exhausted
    output logic [103:0]            m_axis_tdata,
    output logic [1:0]              m_axis_tuser   // [1:0] status
);

    t_cfg              r_cfg;
    logic [1:0]        status;
    logic [DATA_W-1:0] delay_ms;
    logic [DATA_W-1:0] attempts_done;
    logic [DATA_W-1:0] total_waited;
    logic              exhausted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_limit <= '0;
            r_cfg.base_delay  <= DATA_W'(1);
            r_cfg.max_delay   <= DATA_W'(1);
            r_cfg.jitter_max  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_RETRY_LIMIT: r_cfg.retry_limit <= i_cfg_wdata;
                REG_BASE_DELAY:  r_cfg.base_delay  <= i_cfg_wdata;
                REG_MAX_DELAY:   r_cfg.max_delay   <= i_cfg_wdata;
                REG_JITTER_MAX:  r_cfg.jitter_max  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ebjg_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_kind          (s_axis_tuser),
        .i_seed_value    (s_axis_tdata),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_status        (status),
        .o_delay_ms      (delay_ms),
        .o_attempts_done (attempts_done),
        .o_total_waited  (total_waited),
        .o_exhausted     (exhausted)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {7'b0, exhausted, total_waited, attempts_done, delay_ms};

endmodule

`default_nettype wire

### dv/backoff_checker.sv
`timescale 1ns / 1ps
// Passive checker for exponential_backoff_jitter_generator_unit: tracks register
// writes, predicts one result per accepted request and compares the result stream.
// Depends on ebjg_pkg for the port types and the kind, status and register codes.

module backoff_checker
    import ebjg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [DATA_W-1:0]  i_cfg_wdata,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [31:0]        i_req_seed,
    input  logic [1:0]         i_req_kind,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  logic [103:0]       i_rsp_data,
    input  logic [1:0]         i_rsp_status,
    output int                 o_pending,
    output int                 o_fail_count
);

    localparam logic [31:0] LCG_FACTOR = 32'd1103515245;
    localparam logic [31:0] LCG_STEP   = 32'd12345;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] delay_ms;
        logic [31:0] attempts_done;
        logic [31:0] total_waited;
        logic        exhausted;
    } t_backoff_result;

    t_cfg            settings;
    logic [31:0]     lcg_value;
    logic [31:0]     attempts;
    logic [31:0]     waited;
    logic            exhausted_sticky;
    t_backoff_result expected_results[$];
    t_backoff_result seen;
    t_backoff_result want;

    function automatic t_backoff_result advance_backoff(input logic [1:0] kind,
                                                        input logic [31:0] seed);
        t_backoff_result res;
        logic [31:0] ratio;
        logic [31:0] mult;
        logic [31:0] delay;
        logic [63:0] pow;
        logic [32:0] modulus;
        logic [32:0] jitter;
        logic [32:0] sum;
        res = '0;
        delay = '0;
        if (kind == KIND_REQUEST) begin
            if (settings.base_delay == '0 || settings.max_delay < settings.base_delay) begin
                res.status = STAT_INVALID;
            end else if (exhausted_sticky) begin
                res.status = STAT_EXHAUST;
            end else if (settings.retry_limit != '0 && attempts >= settings.retry_limit) begin
                exhausted_sticky = 1'b1;
                res.status = STAT_EXHAUST;
            end else begin
                res.status = STAT_OK;
                ratio = settings.max_delay / settings.base_delay;
                if (attempts >= 32'd32) begin
                    mult = ratio;
                end else begin
                    pow = 64'd1 << attempts[4:0];
                    mult = (pow < {32'd0, ratio}) ? pow[31:0] : ratio;
                end
                delay = settings.base_delay * mult;
                if (settings.jitter_max != '0) begin
                    lcg_value = lcg_value * LCG_FACTOR + LCG_STEP;
                    modulus = {1'b0, settings.jitter_max} + 33'd1;
                    jitter = {18'd0, lcg_value[30:16]} % modulus;
                    sum = {1'b0, delay} + jitter;
                    delay = sum[32] ? '1 : sum[31:0];
                    if (delay > settings.max_delay && settings.jitter_max < settings.max_delay)
                        delay = settings.max_delay;
                end
                if (attempts != '1)
                    attempts = attempts + 32'd1;
                sum = {1'b0, waited} + {1'b0, delay};
                waited = sum[32] ? '1 : sum[31:0];
            end
        end else if (kind == KIND_RESTART) begin
            attempts = '0;
            waited = '0;
            exhausted_sticky = 1'b0;
        end else if (kind == KIND_SEED) begin
            lcg_value = seed;
        end
        res.delay_ms = delay;
        res.attempts_done = attempts;
        res.total_waited = waited;
        res.exhausted = exhausted_sticky;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settings.retry_limit = '0;
            settings.base_delay = 32'd1;
            settings.max_delay = 32'd1;
            settings.jitter_max = '0;
            lcg_value = '0;
            attempts = '0;
            waited = '0;
            exhausted_sticky = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_RETRY_LIMIT: settings.retry_limit = i_cfg_wdata;
                    REG_BASE_DELAY:  settings.base_delay = i_cfg_wdata;
                    REG_MAX_DELAY:   settings.max_delay = i_cfg_wdata;
                    REG_JITTER_MAX:  settings.jitter_max = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                expected_results.push_back(advance_backoff(i_req_kind, i_req_seed));
            if (i_rsp_valid && i_rsp_ready) begin
                seen.status = i_rsp_status;
                seen.delay_ms = i_rsp_data[31:0];
                seen.attempts_done = i_rsp_data[63:32];
                seen.total_waited = i_rsp_data[95:64];
                seen.exhausted = i_rsp_data[96];
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result with no request outstanding", $realtime);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (seen.status !== want.status || seen.delay_ms !== want.delay_ms ||
                        seen.attempts_done !== want.attempts_done ||
                        seen.total_waited !== want.total_waited ||
                        seen.exhausted !== want.exhausted) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: bad result (expected/actual)", $realtime);
                            $display("    status %0d/%0d delay %h/%h exhausted %b/%b",
                                     want.status, seen.status, want.delay_ms, seen.delay_ms,
                                     want.exhausted, seen.exhausted);
                            $display("    attempts %h/%h total %h/%h",
                                     want.attempts_done, seen.attempts_done,
                                     want.total_waited, seen.total_waited);
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Top of the backoff generator testbench: clock, reset, register programming and
// request stimulus with random idling, plus the verdict. Needs backoff_checker.

module testbench;
    import ebjg_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int ITEM_TARGET    = 650;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 100;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_addr;
    logic [DATA_W-1:0]  i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata;   // [31:0] seed_value
    logic [1:0]         s_axis_tuser;   // [1:0] kind
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // [31:0] delay_ms, [63:32] attempts_done, [95:64] total_waited, [96] exhausted
    logic [103:0]       m_axis_tdata;
    logic [1:0]         m_axis_tuser;   // [1:0] status

    int pending_results;
    int fail_total;
    int items_sent;
    int idle_cycles;
    bit sender_eager;
    bit hold_off_req;

    always #1 i_clk = ~i_clk;

    exponential_backoff_jitter_generator_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    backoff_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_seed   (s_axis_tdata),
        .i_req_kind   (s_axis_tuser),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .i_rsp_status (m_axis_tuser),
        .o_pending    (pending_results),
        .o_fail_count (fail_total)
    );

    // Half of the gaps are empty; the rest are mostly short with a few long ones.
    function automatic int gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic t_cfg pick_settings();
        t_cfg c;
        int unsigned r;
        longint unsigned span;
        r = $urandom_range(0, 99);
        if (r < 30)
            c.retry_limit = '0;
        else if (r < 80)
            c.retry_limit = $urandom_range(1, 12);
        else if (r < 90)
            c.retry_limit = $urandom;
        else
            c.retry_limit = '1;
        r = $urandom_range(0, 99);
        if (r < 5)
            c.base_delay = '0;
        else if (r < 65)
            c.base_delay = $urandom_range(1, 20);
        else if (r < 85)
            c.base_delay = $urandom_range(100, 5000);
        else if (r < 95)
            c.base_delay = $urandom;
        else
            c.base_delay = '1;
        r = $urandom_range(0, 99);
        if (r < 6 && c.base_delay != '0) begin
            c.max_delay = $urandom_range(0, c.base_delay - 1);
        end else if (r < 15) begin
            c.max_delay = c.base_delay;
        end else if (r < 75) begin
            span = c.base_delay;
            span = span * $urandom_range(1, 65536);
            c.max_delay = (span > 64'h0000_0000_FFFF_FFFF) ? '1 : span[31:0];
        end else if (r < 90) begin
            c.max_delay = '1;
        end else begin
            c.max_delay = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 25)
            c.jitter_max = '0;
        else if (r < 55)
            c.jitter_max = $urandom_range(1, 100);
        else if (r < 70)
            c.jitter_max = $urandom_range(1, 32'h0000_FFFF);
        else if (r < 80)
            c.jitter_max = (c.max_delay > 32'hFFFF_FF00) ? '1
                         : c.max_delay + $urandom_range(0, 200);
        else if (r < 90)
            c.jitter_max = '1;
        else
            c.jitter_max = $urandom;
        return c;
    endfunction

    task automatic offer(input logic [1:0] kind, input logic [31:0] seed);
        int gap;
        gap = sender_eager ? 0 : gap_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= seed;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
    endtask

    task automatic program_settings(input t_cfg c);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= REG_RETRY_LIMIT;
        i_cfg_wdata <= c.retry_limit;
        @(negedge i_clk);
        i_cfg_addr <= REG_BASE_DELAY;
        i_cfg_wdata <= c.base_delay;
        @(negedge i_clk);
        i_cfg_addr <= REG_MAX_DELAY;
        i_cfg_wdata <= c.max_delay;
        @(negedge i_clk);
        i_cfg_addr <= REG_JITTER_MAX;
        i_cfg_wdata <= c.jitter_max;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_settings(input logic [31:0] limit, input logic [31:0] base,
                                input logic [31:0] cap, input logic [31:0] jitter);
        t_cfg c;
        c.retry_limit = limit;
        c.base_delay = base;
        c.max_delay = cap;
        c.jitter_max = jitter;
        program_settings(c);
    endtask

    task automatic offer_random();
        int unsigned r;
        logic [1:0] kind;
        r = $urandom_range(0, 99);
        if (r < 68)
            kind = KIND_REQUEST;
        else if (r < 80)
            kind = KIND_RESTART;
        else if (r < 95)
            kind = KIND_SEED;
        else
            kind = KIND_UNUSED;
        offer(kind, $urandom);
    endtask

    initial begin
        int phase;
        int count;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_RETRY_LIMIT;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = KIND_REQUEST;
        s_axis_tdata = '0;
        items_sent = 0;
        sender_eager = 1'b0;
        hold_off_req = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: unlimited retries, base and cap of one, no jitter.
        offer(KIND_UNUSED, $urandom);
        offer(KIND_REQUEST, '0);
        offer(KIND_SEED, 32'hFFFF_FFFF);
        offer(KIND_REQUEST, 32'hFFFF_FFFF);

        // Zero base delay is an invalid setting; restart and seed load still work.
        set_settings('0, '0, 32'd100, 32'd5);
        offer(KIND_REQUEST, '0);
        offer(KIND_RESTART, '0);
        offer(KIND_SEED, '0);

        // Cap below the base delay.
        set_settings('0, 32'd5, 32'd3, '0);
        offer(KIND_REQUEST, '0);

        // Full-width jitter range, then the limit is reached and stays sticky.
        set_settings(32'd3, 32'd1, '1, '1);
        offer(KIND_SEED, 32'h1234_5678);
        repeat (5) offer(KIND_REQUEST, '0);
        offer(KIND_RESTART, '0);
        offer(KIND_REQUEST, '0);

        // Largest delays make the running total saturate.
        set_settings('0, '1, '1, '0);
        repeat (3) offer(KIND_REQUEST, '0);
        set_settings('0, '1, '1, 32'h0000_7FFF);
        offer(KIND_REQUEST, '0);

        // Jitter equal to the cap skips the final clamp.
        set_settings('1, 32'd3, 32'd40, 32'd40);
        offer(KIND_RESTART, '0);
        repeat (2) offer(KIND_REQUEST, '0);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            program_settings(pick_settings());
            sender_eager = ($urandom_range(0, 3) == 0);
            count = $urandom_range(30, 70);
            for (int n = 0; n < count; n++) begin
                if ((phase == 1 || phase == 6) && n == 10)
                    hold_off_req = 1'b1;
                offer_random();
            end
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_total == 0 && pending_results == 0)
            $display("exponential_backoff_jitter_generator_unit: match");
        else
            $display("exponential_backoff_jitter_generator_unit: mismatch");
        $finish;
    end

    initial begin
        int stall;
        int eager;
        m_axis_tready = 1'b0;
        stall = 0;
        eager = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (eager > 0) begin
                eager--;
                m_axis_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < 4) begin
                eager = $urandom_range(50, 200);
                m_axis_tready <= 1'b1;
            end else begin
                stall = gap_cycles();
                if (stall > 0) begin
                    stall--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("exponential_backoff_jitter_generator_unit: mismatch");
            $finish;
        end
    end

endmodule
